// File: hw/rtl/tpbpa_pkg.sv
package tpbpa_pkg;

  localparam int SMALL_PAGES_DEF      = 64;
  localparam int LARGE_PAGES_DEF      = 16;
  localparam int SMALL_PAGE_SHIFT_DEF = 12;
  localparam int LARGE_PAGE_SHIFT_DEF = 21;

  localparam int ADDR_W      = 64;
  localparam int CHUNK_W     = 16;
  localparam int CW_BITS     = $clog2(CHUNK_W);
  localparam int QUEUE_DEPTH = 2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;
  localparam logic POOL_SMALL = 1'b0;
  localparam logic POOL_LARGE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_OUT_OF_MEM   = 2'd1,
    ST_OUT_OF_RANGE = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_t;

  typedef struct packed {
    logic mode;
    logic pool;
    logic range_err;
  } job_ctl_t;

  typedef struct packed {
    logic               hit;
    logic [CW_BITS-1:0] pos;
  } fz_t;

  function automatic fz_t first_zero(input logic [CHUNK_W-1:0] w);
    fz_t r;
    r.hit = 1'b0;
    r.pos = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        r.hit = 1'b1;
        r.pos = CW_BITS'(i);
      end
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/tpbpa_front.sv
module tpbpa_front #(
  parameter int SMALL_PAGES      = tpbpa_pkg::SMALL_PAGES_DEF,
  parameter int LARGE_PAGES      = tpbpa_pkg::LARGE_PAGES_DEF,
  parameter int SMALL_PAGE_SHIFT = tpbpa_pkg::SMALL_PAGE_SHIFT_DEF,
  parameter int LARGE_PAGE_SHIFT = tpbpa_pkg::LARGE_PAGE_SHIFT_DEF,
  parameter int IDX_W            = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [tpbpa_pkg::ADDR_W-1:0]  in_tdata,
  input  logic [1:0]                    in_tuser,
  input  logic [tpbpa_pkg::ADDR_W-1:0]  heap_base,
  output logic                          push_valid,
  input  logic                          push_ready,
  output tpbpa_pkg::job_ctl_t           push_ctl,
  output logic [IDX_W-1:0]              push_idx,
  output logic [tpbpa_pkg::ADDR_W-1:0]  push_start
);

  localparam int AW = tpbpa_pkg::ADDR_W;
  localparam logic [AW-1:0] SMALL_SIZE = AW'(SMALL_PAGES) << SMALL_PAGE_SHIFT;
  localparam logic [AW-1:0] LARGE_SIZE = AW'(LARGE_PAGES) << LARGE_PAGE_SHIFT;
  localparam logic [AW-1:0] BOTH_SIZE  = SMALL_SIZE + LARGE_SIZE;

  logic          v_r, v_nxt;
  logic          mode_r, pool_r;
  logic [AW-1:0] addr_r, start_r, lim_r;
  logic [AW-1:0] start_nxt, lim_nxt;
  logic          take;
  logic          wrap, in_rng;
  logic [AW-1:0] offset, shifted;

  assign in_tready = !v_r || push_ready;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    if (in_tuser[1] == tpbpa_pkg::POOL_LARGE) begin
      start_nxt = heap_base + SMALL_SIZE;
      lim_nxt   = heap_base + BOTH_SIZE;
    end else begin
      start_nxt = heap_base;
      lim_nxt   = heap_base + SMALL_SIZE;
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (take) begin
      v_nxt = 1'b1;
    end else if (push_ready) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mode_r  <= in_tuser[0];
      pool_r  <= in_tuser[1];
      addr_r  <= in_tdata;
      start_r <= start_nxt;
      lim_r   <= lim_nxt;
    end
  end

  always_comb begin
    wrap    = lim_r < start_r;
    in_rng  = !wrap && (addr_r >= start_r) && (addr_r < lim_r);
    offset  = addr_r - start_r;
    shifted = (pool_r == tpbpa_pkg::POOL_LARGE) ? (offset >> LARGE_PAGE_SHIFT)
                                                : (offset >> SMALL_PAGE_SHIFT);
  end

  assign push_valid         = v_r;
  assign push_ctl.mode      = mode_r;
  assign push_ctl.pool      = pool_r;
  assign push_ctl.range_err = (mode_r == tpbpa_pkg::MODE_FREE) && !in_rng;
  assign push_idx           = shifted[IDX_W-1:0];
  assign push_start         = start_r;

endmodule

// File: hw/rtl/tpbpa_queue.sv
module tpbpa_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int D     = tpbpa_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (D > 1) ? $clog2(D) : 1;
  localparam int CNT_W = $clog2(D + 1);

  logic [W-1:0]     mem_r [D];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = cnt_r != CNT_W'(D);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(D - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(D - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: hw/rtl/tpbpa_back.sv
module tpbpa_back #(
  parameter int SMALL_PAGES      = tpbpa_pkg::SMALL_PAGES_DEF,
  parameter int LARGE_PAGES      = tpbpa_pkg::LARGE_PAGES_DEF,
  parameter int SMALL_PAGE_SHIFT = tpbpa_pkg::SMALL_PAGE_SHIFT_DEF,
  parameter int LARGE_PAGE_SHIFT = tpbpa_pkg::LARGE_PAGE_SHIFT_DEF,
  parameter int IDX_W            = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  tpbpa_pkg::job_ctl_t           pop_ctl,
  input  logic [IDX_W-1:0]              pop_idx,
  input  logic [tpbpa_pkg::ADDR_W-1:0]  pop_start,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [tpbpa_pkg::ADDR_W-1:0]  out_tdata,
  output logic [1:0]                    out_tuser
);

  localparam int AW     = tpbpa_pkg::ADDR_W;
  localparam int CW     = tpbpa_pkg::CHUNK_W;
  localparam int CWB    = tpbpa_pkg::CW_BITS;
  localparam int NCH_S  = (SMALL_PAGES + CW - 1) / CW;
  localparam int NCH_L  = (LARGE_PAGES + CW - 1) / CW;
  localparam int NCH    = (NCH_S > NCH_L) ? NCH_S : NCH_L;
  localparam int CHI_W  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int FIDX_W = CHI_W + CWB;
  localparam int MAP_W  = NCH * CW;
  localparam int SI_W   = (SMALL_PAGES > 1) ? $clog2(SMALL_PAGES) : 1;
  localparam int LI_W   = (LARGE_PAGES > 1) ? $clog2(LARGE_PAGES) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic                   mode_r, mode_nxt;
  logic                   pool_r, pool_nxt;
  logic                   err_r, err_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [AW-1:0]          start_r, start_nxt;
  logic [CHI_W-1:0]       ch_r, ch_nxt;
  logic [FIDX_W-1:0]      found_r, found_nxt;
  tpbpa_pkg::status_t     stat_r, stat_nxt;
  logic [SMALL_PAGES-1:0] small_r, small_nxt;
  logic [LARGE_PAGES-1:0] large_r, large_nxt;
  logic                   out_v_r, out_v_nxt;
  logic [AW-1:0]          out_addr_r, out_addr_nxt;
  tpbpa_pkg::status_t     out_stat_r, out_stat_nxt;

  logic [MAP_W-1:0]       small_pad, large_pad, sel_map;
  logic [CW-1:0]          chunk;
  tpbpa_pkg::fz_t         fz;
  logic [FIDX_W-1:0]      fidx;
  logic [CHI_W-1:0]       last_ch;
  logic                   cur_bit;
  logic                   out_free;
  logic                   load;
  logic [AW-1:0]          found_wide, page_off;

  always_comb begin
    small_pad = '1;
    small_pad[SMALL_PAGES-1:0] = small_r;
    large_pad = '1;
    large_pad[LARGE_PAGES-1:0] = large_r;
  end

  assign sel_map  = (pool_r == tpbpa_pkg::POOL_LARGE) ? large_pad : small_pad;
  assign chunk    = sel_map[ch_r*CW +: CW];
  assign fz       = tpbpa_pkg::first_zero(chunk);
  assign fidx     = {ch_r, fz.pos};
  assign last_ch  = (pool_r == tpbpa_pkg::POOL_LARGE) ? CHI_W'(NCH_L - 1)
                                                      : CHI_W'(NCH_S - 1);
  assign cur_bit  = (pool_r == tpbpa_pkg::POOL_LARGE) ? large_r[idx_r[LI_W-1:0]]
                                                      : small_r[idx_r[SI_W-1:0]];
  assign out_free = !out_v_r || out_tready;

  assign found_wide = AW'(found_r);
  assign page_off   = (pool_r == tpbpa_pkg::POOL_LARGE) ? (found_wide << LARGE_PAGE_SHIFT)
                                                        : (found_wide << SMALL_PAGE_SHIFT);

  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    pool_nxt     = pool_r;
    err_nxt      = err_r;
    idx_nxt      = idx_r;
    start_nxt    = start_r;
    ch_nxt       = ch_r;
    found_nxt    = found_r;
    stat_nxt     = stat_r;
    small_nxt    = small_r;
    large_nxt    = large_r;
    out_v_nxt    = out_v_r && !out_tready;
    out_addr_nxt = out_addr_r;
    out_stat_nxt = out_stat_r;
    load         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        load = pop_valid;
      end
      S_EXEC: begin
        if (err_r) begin
          stat_nxt  = tpbpa_pkg::ST_OUT_OF_RANGE;
          state_nxt = S_FIN;
        end else if (mode_r == tpbpa_pkg::MODE_FREE) begin
          if (!cur_bit) begin
            stat_nxt = tpbpa_pkg::ST_ALREADY_FREE;
          end else begin
            stat_nxt = tpbpa_pkg::ST_OK;
            if (pool_r == tpbpa_pkg::POOL_LARGE) begin
              large_nxt[idx_r[LI_W-1:0]] = 1'b0;
            end else begin
              small_nxt[idx_r[SI_W-1:0]] = 1'b0;
            end
          end
          state_nxt = S_FIN;
        end else if (fz.hit) begin
          found_nxt = fidx;
          stat_nxt  = tpbpa_pkg::ST_OK;
          if (pool_r == tpbpa_pkg::POOL_LARGE) begin
            large_nxt[fidx[LI_W-1:0]] = 1'b1;
          end else begin
            small_nxt[fidx[SI_W-1:0]] = 1'b1;
          end
          state_nxt = S_FIN;
        end else if (ch_r == last_ch) begin
          stat_nxt  = tpbpa_pkg::ST_OUT_OF_MEM;
          state_nxt = S_FIN;
        end else begin
          ch_nxt = ch_r + 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_v_nxt    = 1'b1;
          out_stat_nxt = stat_r;
          if (mode_r == tpbpa_pkg::MODE_ALLOC && stat_r == tpbpa_pkg::ST_OK) begin
            out_addr_nxt = start_r + page_off;
          end else begin
            out_addr_nxt = '0;
          end
          load      = pop_valid;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (load) begin
      mode_nxt  = pop_ctl.mode;
      pool_nxt  = pop_ctl.pool;
      err_nxt   = pop_ctl.range_err;
      idx_nxt   = pop_idx;
      start_nxt = pop_start;
      ch_nxt    = '0;
      state_nxt = S_EXEC;
    end
  end

  assign pop_ready = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      small_r <= '0;
      large_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      small_r <= small_nxt;
      large_r <= large_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    pool_r     <= pool_nxt;
    err_r      <= err_nxt;
    idx_r      <= idx_nxt;
    start_r    <= start_nxt;
    ch_r       <= ch_nxt;
    found_r    <= found_nxt;
    stat_r     <= stat_nxt;
    out_addr_r <= out_addr_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = out_stat_r;

endmodule

// File: hw/rtl/two_pool_bitmap_page_allocator.sv
// Page allocator for two pools: SMALL_PAGES pages of 2^SMALL_PAGE_SHIFT bytes
// starting at heap_base, then LARGE_PAGES pages of 2^LARGE_PAGE_SHIFT bytes.
// Alloc returns the lowest free page of the pool; free checks range and
// usage and reports a status. Both bitmaps are cleared by reset, with no
// clearing pass. The front forms the pool bounds as a beat is taken and holds
// the request in registers, from which it forms the range check and page index,
// until it pushes it into a 2-entry queue; the back pops it when idle or as it
// issues a result, and scans the bitmap 16 pages per cycle. In the back a free
// passes a check state and a result state; an alloc scans 16-page groups up to
// the first free page (1 to ceil(pages/16) groups, all groups when the pool is
// full), then forms the page address in its result state. The back takes the
// next request from the queue as it registers a result. Program heap_base only
// while idle, aligned to both page sizes.
module two_pool_bitmap_page_allocator #(
  parameter int SMALL_PAGES      = tpbpa_pkg::SMALL_PAGES_DEF,
  parameter int LARGE_PAGES      = tpbpa_pkg::LARGE_PAGES_DEF,
  parameter int SMALL_PAGE_SHIFT = tpbpa_pkg::SMALL_PAGE_SHIFT_DEF,
  parameter int LARGE_PAGE_SHIFT = tpbpa_pkg::LARGE_PAGE_SHIFT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data,    // heap_base
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,    // address
  input  logic [1:0]  in_tuser,    // mode, pool
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // page_address
  output logic [1:0]  out_tuser    // status
);

  localparam int AW    = tpbpa_pkg::ADDR_W;
  localparam int MAXP  = (SMALL_PAGES > LARGE_PAGES) ? SMALL_PAGES : LARGE_PAGES;
  localparam int IDX_W = (MAXP > 1) ? $clog2(MAXP) : 1;
  localparam int CTL_W = $bits(tpbpa_pkg::job_ctl_t);
  localparam int Q_W   = CTL_W + IDX_W + AW;

  logic [AW-1:0]       heap_base_r;
  logic                push_valid, push_ready;
  tpbpa_pkg::job_ctl_t push_ctl, pop_ctl;
  logic [IDX_W-1:0]    push_idx, pop_idx;
  logic [AW-1:0]       push_start, pop_start;
  logic                pop_valid, pop_ready;
  logic [Q_W-1:0]      push_data, pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r <= '0;
    end else if (cfg_valid) begin
      heap_base_r <= cfg_data;
    end
  end

  tpbpa_front #(
    .SMALL_PAGES      (SMALL_PAGES),
    .LARGE_PAGES      (LARGE_PAGES),
    .SMALL_PAGE_SHIFT (SMALL_PAGE_SHIFT),
    .LARGE_PAGE_SHIFT (LARGE_PAGE_SHIFT),
    .IDX_W            (IDX_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .heap_base  (heap_base_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_ctl   (push_ctl),
    .push_idx   (push_idx),
    .push_start (push_start)
  );

  assign push_data = {push_ctl, push_idx, push_start};

  tpbpa_queue #(
    .W (Q_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign pop_ctl   = pop_data[Q_W-1 -: CTL_W];
  assign pop_idx   = pop_data[AW +: IDX_W];
  assign pop_start = pop_data[AW-1:0];

  tpbpa_back #(
    .SMALL_PAGES      (SMALL_PAGES),
    .LARGE_PAGES      (LARGE_PAGES),
    .SMALL_PAGE_SHIFT (SMALL_PAGE_SHIFT),
    .LARGE_PAGE_SHIFT (LARGE_PAGE_SHIFT),
    .IDX_W            (IDX_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_ctl    (pop_ctl),
    .pop_idx    (pop_idx),
    .pop_start  (pop_start),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: dv/two_pool_bitmap_page_allocator_tb.sv
`timescale 1ns / 1ps

module two_pool_bitmap_page_allocator_tb;

  localparam int RUN_ITEMS    = 1400;
  localparam int SEGMENTS     = 8;
  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 24;
  localparam int TAIL_CYCLES  = 40;
  localparam int MAX_PAGES    = (tpbpa_pkg::SMALL_PAGES_DEF > tpbpa_pkg::LARGE_PAGES_DEF) ?
                                tpbpa_pkg::SMALL_PAGES_DEF : tpbpa_pkg::LARGE_PAGES_DEF;
  localparam logic [63:0] SMALL_SPAN = 64'(tpbpa_pkg::SMALL_PAGES_DEF)
                                       << tpbpa_pkg::SMALL_PAGE_SHIFT_DEF;
  localparam logic [63:0] LARGE_SPAN = 64'(tpbpa_pkg::LARGE_PAGES_DEF)
                                       << tpbpa_pkg::LARGE_PAGE_SHIFT_DEF;
  localparam logic [63:0] BASE_TOP   = 64'hFFFF_FFFF_FFE0_0000;
  localparam logic [63:0] BASE_MASK  = ~((64'd1 << tpbpa_pkg::LARGE_PAGE_SHIFT_DEF) - 64'd1);

  typedef struct {
    logic [63:0]        page_address;
    tpbpa_pkg::status_t status;
  } grant_t;

  class page_grant_book;
    logic [63:0] heap_base;
    bit          page_used [2][MAX_PAGES];
    grant_t      grant_q[$];
    int          mismatches;

    function new();
      heap_base  = '0;
      mismatches = 0;
      foreach (page_used[p, i]) page_used[p][i] = 1'b0;
    endfunction

    function int pool_pages(logic pool);
      return (pool == tpbpa_pkg::POOL_LARGE) ? tpbpa_pkg::LARGE_PAGES_DEF
                                             : tpbpa_pkg::SMALL_PAGES_DEF;
    endfunction

    function int pool_shift(logic pool);
      return (pool == tpbpa_pkg::POOL_LARGE) ? tpbpa_pkg::LARGE_PAGE_SHIFT_DEF
                                             : tpbpa_pkg::SMALL_PAGE_SHIFT_DEF;
    endfunction

    function logic [63:0] pool_start(logic pool);
      return (pool == tpbpa_pkg::POOL_LARGE) ? heap_base + SMALL_SPAN : heap_base;
    endfunction

    function logic [63:0] pool_stop(logic pool);
      return pool_start(pool) +
             ((pool == tpbpa_pkg::POOL_LARGE) ? LARGE_SPAN : SMALL_SPAN);
    endfunction

    function void note_request(logic mode, logic pool, logic [63:0] addr);
      grant_t      g;
      logic [63:0] start;
      logic [63:0] stop;
      logic [63:0] idx;
      int          pages;
      int          shift;
      bit          found;
      start = pool_start(pool);
      stop  = pool_stop(pool);
      pages = pool_pages(pool);
      shift = pool_shift(pool);
      found = 1'b0;
      g.page_address = '0;
      g.status       = tpbpa_pkg::ST_OK;
      if (mode == tpbpa_pkg::MODE_ALLOC) begin
        for (int i = 0; i < pages && !found; i++) begin
          if (!page_used[pool][i]) begin
            page_used[pool][i] = 1'b1;
            g.page_address = start + (64'(i) << shift);
            found = 1'b1;
          end
        end
        if (!found) g.status = tpbpa_pkg::ST_OUT_OF_MEM;
      end else if (addr < start || addr >= stop) begin
        g.status = tpbpa_pkg::ST_OUT_OF_RANGE;
      end else begin
        idx = (addr - start) >> shift;
        if (idx >= 64'(pages)) g.status = tpbpa_pkg::ST_OUT_OF_RANGE;
        else if (!page_used[pool][int'(idx)]) g.status = tpbpa_pkg::ST_ALREADY_FREE;
        else page_used[pool][int'(idx)] = 1'b0;
      end
      grant_q.push_back(g);
    endfunction

    function void check_grant(logic [63:0] page_address, logic [1:0] status);
      grant_t g;
      if (grant_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: page_address=%h status=%0d", page_address, status);
        return;
      end
      g = grant_q.pop_front();
      if (page_address !== g.page_address || status !== g.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: page_address exp=%h act=%h status exp=%0d act=%0d",
                   g.page_address, page_address, g.status, status);
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_data   = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;   // address
  logic [1:0]  in_tuser   = '0;   // mode, pool
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;         // page_address
  logic [1:0]  out_tuser;         // status

  page_grant_book book;
  int             burst_left;
  int             cycle_count = 0;
  int             rx_cycles   = 0;
  int             stall_left  = 0;
  int             stall_pct   = 0;
  int             stall_max   = 1;

  two_pool_bitmap_page_allocator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("two_pool_bitmap_page_allocator test failed");
      $finish;
    end
  end

  // check result beats and stall the result side in changing patterns
  always @(posedge clk) begin
    rx_cycles++;
    if (rst_n && out_tvalid && out_tready) book.check_grant(out_tdata, out_tuser);
    if (rx_cycles % 300 == 0) begin
      case ($urandom_range(3))
        0: begin stall_pct = 0;  stall_max = 1;  end
        1: begin stall_pct = 10; stall_max = 3;  end
        2: begin stall_pct = 40; stall_max = 6;  end
        default: begin stall_pct = 5; stall_max = 25; end
      endcase
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(99) < stall_pct) stall_left = $urandom_range(1, stall_max);
    end
  end

  task automatic send_request(logic mode, logic pool, logic [63:0] addr);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= addr;
    in_tuser  <= {pool, mode};
    do @(posedge clk); while (!in_tready);
    book.note_request(mode, pool, addr);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic write_heap_base(logic [63:0] base);
    in_tvalid <= 1'b0;
    while (book.grant_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= base;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    book.heap_base = base;
  endtask

  function automatic logic [63:0] pick_free_address(logic pool);
    logic [63:0] start;
    logic [63:0] offset;
    int          shift;
    int          pages;
    int          idx;
    int          kind;
    start  = book.pool_start(pool);
    shift  = book.pool_shift(pool);
    pages  = book.pool_pages(pool);
    kind   = $urandom_range(9);
    offset = ($urandom_range(1) == 0) ? 64'd0 :
             ({$urandom, $urandom} & ((64'd1 << shift) - 64'd1));
    idx    = $urandom_range(pages - 1);
    if (kind <= 4) begin
      for (int t = 0; t < 8 && !book.page_used[pool][idx]; t++)
        idx = $urandom_range(pages - 1);
    end
    case (kind)
      7: begin
        case ($urandom_range(3))
          0: return start - 64'd1;
          1: return start;
          2: return book.pool_stop(pool) - 64'd1;
          default: return book.pool_stop(pool);
        endcase
      end
      8: return {$urandom, $urandom};
      9: return book.pool_start(~pool) +
                (64'($urandom_range(book.pool_pages(~pool) - 1)) << book.pool_shift(~pool));
      default: return start + (64'(idx) << shift) + offset;
    endcase
  endfunction

  initial begin
    logic [63:0] base;
    logic        pool;
    int          bias;
    book       = new();
    burst_left = 1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(tpbpa_pkg::MODE_ALLOC, tpbpa_pkg::POOL_SMALL, '1);
    send_request(tpbpa_pkg::MODE_ALLOC, tpbpa_pkg::POOL_LARGE, '0);
    send_request(tpbpa_pkg::MODE_FREE,  tpbpa_pkg::POOL_SMALL, 64'h0);
    send_request(tpbpa_pkg::MODE_FREE,  tpbpa_pkg::POOL_SMALL, 64'h0);
    send_request(tpbpa_pkg::MODE_ALLOC, tpbpa_pkg::POOL_SMALL, '0);
    send_request(tpbpa_pkg::MODE_FREE,  tpbpa_pkg::POOL_SMALL, 64'h0FFF);
    send_request(tpbpa_pkg::MODE_FREE,  tpbpa_pkg::POOL_LARGE, SMALL_SPAN + 64'h1F_FFFF);
    send_request(tpbpa_pkg::MODE_FREE,  tpbpa_pkg::POOL_SMALL, SMALL_SPAN);
    send_request(tpbpa_pkg::MODE_FREE,  tpbpa_pkg::POOL_SMALL, SMALL_SPAN - 64'd1);
    send_request(tpbpa_pkg::MODE_FREE,  tpbpa_pkg::POOL_LARGE, SMALL_SPAN - 64'd1);
    send_request(tpbpa_pkg::MODE_FREE,  tpbpa_pkg::POOL_LARGE, SMALL_SPAN + LARGE_SPAN);
    send_request(tpbpa_pkg::MODE_FREE,  tpbpa_pkg::POOL_SMALL, '1);

    // large pool end wraps past zero at the top base
    write_heap_base(BASE_TOP);
    send_request(tpbpa_pkg::MODE_ALLOC, tpbpa_pkg::POOL_LARGE, '0);
    send_request(tpbpa_pkg::MODE_ALLOC, tpbpa_pkg::POOL_LARGE, '0);
    send_request(tpbpa_pkg::MODE_FREE,  tpbpa_pkg::POOL_LARGE, BASE_TOP + SMALL_SPAN);
    send_request(tpbpa_pkg::MODE_ALLOC, tpbpa_pkg::POOL_SMALL, '0);
    send_request(tpbpa_pkg::MODE_FREE,  tpbpa_pkg::POOL_SMALL, BASE_TOP + 64'h123);
    send_request(tpbpa_pkg::MODE_FREE,  tpbpa_pkg::POOL_SMALL, '1);

    for (int s = 0; s < SEGMENTS; s++) begin
      case (s)
        0: base = 64'h0;
        1: base = 64'h0000_0000_0020_0000;
        2: base = BASE_TOP;
        4: base = 64'hFFFF_FFFF_FE00_0000;
        6: base = 64'h0;
        7: base = {1'b1, 63'($urandom)} & BASE_MASK;
        default: base = {$urandom, $urandom} & BASE_MASK;
      endcase
      write_heap_base(base);
      case (s)
        0: bias = 92;
        1: bias = 15;
        default: bias = $urandom_range(30, 85);
      endcase
      for (int n = 0; n < RUN_ITEMS / SEGMENTS; n++) begin
        pool = 1'($urandom_range(1));
        if ($urandom_range(99) < bias)
          send_request(tpbpa_pkg::MODE_ALLOC, pool, {$urandom, $urandom});
        else
          send_request(tpbpa_pkg::MODE_FREE, pool, pick_free_address(pool));
      end
    end

    in_tvalid <= 1'b0;
    while (book.grant_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (book.mismatches == 0 && book.grant_q.size() == 0) begin
      $display("two_pool_bitmap_page_allocator test passed");
    end else begin
      $display("two_pool_bitmap_page_allocator test failed");
    end
    $finish;
  end

endmodule

// File: two_pool_bitmap_page_allocator.f
hw/rtl/tpbpa_pkg.sv
hw/rtl/tpbpa_front.sv
hw/rtl/tpbpa_queue.sv
hw/rtl/tpbpa_back.sv
hw/rtl/two_pool_bitmap_page_allocator.sv
dv/two_pool_bitmap_page_allocator_tb.sv
